[hw/rtl/evhp_pkg.sv]
// Shared types and constants of the Ethernet VLAN header parser.
package evhp_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;

    localparam logic [15:0] ETYPE_FABRIC = 16'h8903;
    localparam logic [15:0] ETYPE_CTAG   = 16'h8100;
    localparam logic [15:0] ETYPE_STAG   = 16'h9100;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_PREFIX_TRUNC = 2'd1;
    localparam logic [1:0] ST_LINK_TRUNC   = 2'd2;

    localparam int unsigned RESULT_BITS = 159;
    localparam int unsigned TDATA_BITS  = 160;

    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [15:0] payload_offset;
        logic        fabric_path_seen;
        logic [3:0]  vlan_tags;
        logic [11:0] inner_vid;
        logic [11:0] outer_vlan;
        logic [15:0] next_protocol;
        logic [1:0]  status;
    } t_result;

    function automatic logic is_tag(input logic [15:0] etype);
        return (etype == ETYPE_CTAG) || (etype == ETYPE_STAG);
    endfunction

endpackage

[hw/rtl/evhp_parse_core.sv]
// Per-byte header parsing state and the result computed on the last byte.
module evhp_parse_core #(
    parameter int unsigned COUNT_BITS = evhp_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output evhp_pkg::t_result o_result
);
    import evhp_pkg::*;

    localparam int unsigned WB = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef enum logic [1:0] {
        PH_LINK,
        PH_PREFIX,
        PH_TAG,
        PH_PAYLOAD
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] r_base, n_base;
    logic [47:0]           r_dst, n_dst;
    logic [47:0]           r_src, n_src;
    logic [15:0]           r_proto, n_proto;
    logic [11:0]           r_outer, n_outer;
    logic [11:0]           r_inner, n_inner;
    logic [3:0]            r_tags, n_tags;
    logic                  r_prefix, n_prefix;

    logic                  sat;
    logic [1:0]            tag_pos;
    logic [11:0]           vlan_cur;
    logic [11:0]           vlan_new;
    logic [15:0]           proto_full;
    logic [1:0]            status;
    logic [WB-1:0]         base_wide;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_base   = r_base;
        n_dst    = r_dst;
        n_src    = r_src;
        n_proto  = r_proto;
        n_outer  = r_outer;
        n_inner  = r_inner;
        n_tags   = r_tags;
        n_prefix = r_prefix;
        sat        = (r_count == {COUNT_BITS{1'b1}});
        tag_pos    = r_count[1:0] - r_base[1:0];
        vlan_cur   = (r_tags == 4'd0) ? r_outer : r_inner;
        vlan_new   = vlan_cur;
        proto_full = {r_proto[15:8], i_byte};

        case (r_phase)
            PH_LINK: begin
                if (r_count < COUNT_BITS'(12)) begin
                    if (r_count < COUNT_BITS'(6)) begin
                        n_dst = {r_dst[39:0], i_byte};
                    end else begin
                        n_src = {r_src[39:0], i_byte};
                    end
                end else if (r_count == COUNT_BITS'(12)) begin
                    n_proto = {i_byte, 8'h00};
                end else begin
                    n_proto = proto_full;
                    if (proto_full == ETYPE_FABRIC) begin
                        n_prefix = 1'b1;
                        n_dst    = '0;
                        n_src    = '0;
                        n_phase  = PH_PREFIX;
                    end else begin
                        n_base  = COUNT_BITS'(14);
                        n_phase = is_tag(proto_full) ? PH_TAG : PH_PAYLOAD;
                    end
                end
            end
            PH_PREFIX: begin
                if (r_count >= COUNT_BITS'(16) && r_count < COUNT_BITS'(28)) begin
                    if (r_count < COUNT_BITS'(22)) begin
                        n_dst = {r_dst[39:0], i_byte};
                    end else begin
                        n_src = {r_src[39:0], i_byte};
                    end
                end else if (r_count == COUNT_BITS'(28)) begin
                    n_proto = {i_byte, 8'h00};
                end else if (r_count >= COUNT_BITS'(29)) begin
                    n_proto = proto_full;
                    n_base  = COUNT_BITS'(30);
                    n_phase = is_tag(proto_full) ? PH_TAG : PH_PAYLOAD;
                end
            end
            PH_TAG: begin
                if (!sat) begin
                    case (tag_pos)
                        2'd0: vlan_new = {i_byte[3:0], 8'h00};
                        2'd1: vlan_new = {vlan_cur[11:8], i_byte};
                        2'd2: n_proto = {i_byte, 8'h00};
                        default: begin
                            n_proto = proto_full;
                            if (r_tags != 4'hF) begin
                                n_tags = r_tags + 4'd1;
                            end
                            n_base  = r_count + COUNT_BITS'(1);
                            n_phase = is_tag(proto_full) ? PH_TAG : PH_PAYLOAD;
                        end
                    endcase
                    if (r_tags == 4'd0) begin
                        n_outer = vlan_new;
                    end else begin
                        n_inner = vlan_new;
                    end
                end
            end
            default: begin
            end
        endcase

        if (!sat) begin
            n_count = r_count + COUNT_BITS'(1);
        end

        case (r_phase)
            PH_LINK: begin
                if (r_count < COUNT_BITS'(13)) begin
                    status = ST_LINK_TRUNC;
                end else if (n_phase == PH_PREFIX) begin
                    status = ST_PREFIX_TRUNC;
                end else if (n_phase == PH_TAG) begin
                    status = ST_LINK_TRUNC;
                end else begin
                    status = ST_OK;
                end
            end
            PH_PREFIX: status = ST_PREFIX_TRUNC;
            PH_TAG:    status = ST_LINK_TRUNC;
            default:   status = ST_OK;
        endcase

        base_wide = WB'(n_base);
        o_result  = '0;
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.next_protocol    = n_proto;
            o_result.outer_vlan       = n_outer;
            o_result.inner_vid        = n_inner;
            o_result.vlan_tags        = n_tags;
            o_result.fabric_path_seen = n_prefix;
            o_result.payload_offset   = (base_wide > WB'(17'h0FFFF)) ? 16'hFFFF
                                                                     : base_wide[15:0];
            o_result.dst_mac          = n_dst;
            o_result.src_mac          = n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase  <= PH_LINK;
            r_count  <= '0;
            r_base   <= '0;
            r_dst    <= '0;
            r_src    <= '0;
            r_proto  <= '0;
            r_outer  <= '0;
            r_inner  <= '0;
            r_tags   <= '0;
            r_prefix <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_base   <= n_base;
            r_dst    <= n_dst;
            r_src    <= n_src;
            r_proto  <= n_proto;
            r_outer  <= n_outer;
            r_inner  <= n_inner;
            r_tags   <= n_tags;
            r_prefix <= n_prefix;
        end
    end

endmodule

[hw/rtl/ethernet_vlan_header_parser.sv]
// Top level of the Ethernet VLAN header parser: input register, parser and result register.
//
// A frame enters on the slave stream one byte per item, starting at the link
// header, with tlast on its final byte. Bytes 12 and 13 equal to 0x8903 mark a
// 16-byte prefix that is skipped. A chain of 0x8100 or 0x9100 tags is followed,
// the first tag giving the outer VLAN and later ones the inner VLAN.
// Exactly one result item leaves on the master stream per frame, after the last
// byte. A byte is taken into an input register, from which it either updates
// the parser state or, for the last byte, loads the result register.
// One byte is accepted in every cycle while the slave side is not stalled;
// the input register and the result register keep the two sides apart. When
// the receiver stalls, the result is held and further bytes of the next frame
// still pass until that frame's last byte reaches the input register, where the
// slave side then waits.
// Synchronous reset clears the parser to the start of a frame and drops any
// pending item. A nonzero status clears every other result field.
module ethernet_vlan_header_parser #(
    parameter int unsigned COUNT_BITS = evhp_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // data_byte [7:0]
    input  logic                              i_s_tlast,  // last_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status [1:0], next_protocol [17:2], outer_vlan [29:18], inner_vid [41:30],
    // vlan_tags [45:42], fabric_path_seen [46], payload_offset [62:47],
    // dst_mac [110:63], src_mac [158:111], zero [159]
    output logic [evhp_pkg::TDATA_BITS-1:0]   o_m_tdata
);
    import evhp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       step;
    logic       load;

    assign step = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign load = step && r_in_last;

    assign o_s_tready = !r_in_valid || step;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(TDATA_BITS-RESULT_BITS){1'b0}}, r_out};

    evhp_parse_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (load) begin
            r_out <= core_result;
        end
    end

    a_fail_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status != ST_OK) |-> (r_out[RESULT_BITS-1:2] == '0))
        else $error("failed result carries nonzero fields");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status == ST_OK) || (r_out.status == ST_PREFIX_TRUNC) ||
                        (r_out.status == ST_LINK_TRUNC))
        else $error("illegal status code");

    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && r_in_last && r_out_valid && !i_m_tready)
        else $error("input stalled without a blocked result");

    a_prefix_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_OK) && r_out.fabric_path_seen
            |-> (r_out.payload_offset >= 16'd30))
        else $error("prefixed frame with short payload offset");

endmodule
